>>> src/bilinear_kick_map_interpolator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear kick map interpolator.
// Each macro expects i_clk (BKMI_ASSERT_RST also i_rst_n) visible where used.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_KICK_MAP_INTERPOLATOR_UNIT_ASSERT_SVH
`define BILINEAR_KICK_MAP_INTERPOLATOR_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define BKMI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BKMI_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/bkmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkmi_pkg
// Shared constants, types and helpers of the bilinear kick map interpolator.
// ----------------------------------------------------------------------------
package bkmi_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int POS_W       = 32;
    localparam int KICK_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int IDX_W       = 6;
    localparam int MAP_ADDR_W  = 14;
    localparam int WEIGHT_W    = 31;
    localparam int GRID_DEPTH  = 64;
    localparam int MAP_DEPTH   = 16384;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 31'h4000_0000;
    localparam logic [COUNT_W-1:0]  COUNT_MIN  = 7'd2;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 7'd64;

    typedef enum logic [1:0] {
        OP_WR_X   = 2'd0,
        OP_WR_Z   = 2'd1,
        OP_WR_MAP = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic {
        CFG_COLUMNS = 1'b0,
        CFG_ROWS    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_opcode                  op;
        logic [MAP_ADDR_W-1:0]    map_addr;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic [KICK_W-1:0]        value;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  pz;
        logic                     order;
    } t_item;

    function automatic logic [COUNT_W-1:0] clamp_count(
        input logic [COUNT_W-1:0] v,
        input logic [COUNT_W-1:0] top
    );
        logic [COUNT_W-1:0] r;
        if (v < COUNT_MIN) begin
            r = COUNT_MIN;
        end else if (v > top) begin
            r = top;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> src/bkmi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkmi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bkmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bkmi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkmi_front
// Accepts requests, decodes the opcode and forms the queue entry.
// ----------------------------------------------------------------------------
module bkmi_front (
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [1:0]                          i_map_select,
    input  logic [bkmi_pkg::IDX_W-1:0]          i_column_index,
    input  logic [bkmi_pkg::IDX_W-1:0]          i_row_index,
    input  logic signed [bkmi_pkg::KICK_W-1:0]  i_write_value,
    input  logic signed [bkmi_pkg::POS_W-1:0]   i_position_x,
    input  logic signed [bkmi_pkg::POS_W-1:0]   i_position_z,
    input  logic                                i_kick_order,
    input  logic                                i_full,
    output logic                                o_push,
    output bkmi_pkg::t_item                     o_item
);

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_item.op       = bkmi_pkg::t_opcode'(i_opcode);
        o_item.map_addr = {i_map_select, i_row_index, i_column_index};
        o_item.col      = i_column_index;
        o_item.row      = i_row_index;
        o_item.value    = i_write_value;
        o_item.px       = i_position_x;
        o_item.pz       = i_position_z;
        o_item.order    = i_kick_order;
    end

endmodule

>>> src/bkmi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkmi_queue
// Two-entry queue between the decoding front end and the execution back end.
// ----------------------------------------------------------------------------
module bkmi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bkmi_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output bkmi_pkg::t_item o_item
);

    bkmi_pkg::t_item r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

>>> src/bkmi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkmi_back
// Executes writes and queries: grid search, serial division, bilinear blend.
// ----------------------------------------------------------------------------
module bkmi_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_item_valid,
    input  bkmi_pkg::t_item                    i_item,
    output logic                               o_pop,
    input  logic [bkmi_pkg::COUNT_W-1:0]       i_col_count,
    input  logic [bkmi_pkg::COUNT_W-1:0]       i_row_count,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [bkmi_pkg::KICK_W-1:0] o_kick_x,
    output logic signed [bkmi_pkg::KICK_W-1:0] o_kick_z,
    output logic                               o_outside_map
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RDN, S_CHK, S_SRCH, S_GIX,
        S_DSET, S_DCHK, S_DIV, S_CW, S_MAC, S_FIN
    } t_state;

    localparam logic signed [64:0] PROD_HALF = 65'sh0_2000_0000;
    localparam logic signed [65:0] ACC_HALF  = 66'sh0_2000_0000;
    localparam logic signed [35:0] KICK_MAX  = 36'sd2147483647;
    localparam logic signed [35:0] KICK_MIN  = -36'sd2147483648;

    function automatic logic [31:0] sat_kick(input logic signed [65:0] acc);
        logic signed [65:0] s;
        logic signed [35:0] q;
        logic [31:0]        r;
        s = acc + ACC_HALF;
        q = $signed(s[65:30]);
        if (q > KICK_MAX) begin
            r = 32'h7FFF_FFFF;
        end else if (q < KICK_MIN) begin
            r = 32'h8000_0000;
        end else begin
            r = q[31:0];
        end
        return r;
    endfunction

    t_state                   r_state;
    logic signed [31:0]       r_px, r_pz;
    logic                     r_order;
    logic signed [31:0]       r_gx0, r_gx1, r_gz0, r_gz1;
    logic [6:0]               r_xi, r_zi;
    logic                     r_xdone, r_zdone;
    logic [5:0]               r_ix, r_iz;
    logic [31:0]              r_xstep, r_xrem, r_zstep, r_zrem;
    logic                     r_xok, r_zok, r_xsp, r_zsp;
    logic [30:0]              r_u, r_t;
    logic [4:0]               r_cnt;
    logic [30:0]              r_cw [4];
    logic signed [64:0]       r_prod;
    logic signed [65:0]       r_accx, r_accz;
    logic                     r_outside;
    logic                     r_out_valid;
    logic [31:0]              r_kx, r_kz;
    logic                     r_ov;

    logic [5:0]               x_raddr, z_raddr;
    logic [13:0]              m_raddr;
    logic [31:0]              x_rdata, z_rdata, m_rdata;
    logic                     x_we, z_we, m_we;
    logic                     x_pass, z_pass, x_stop, z_stop;
    logic [6:0]               xi_m1, zi_m1, x_lim, z_lim;
    logic [5:0]               n_ix, n_iz;
    logic signed [32:0]       x_dc, x_da, z_dc, z_da;
    logic [32:0]              x_rem2, z_rem2;
    logic [30:0]              cw_a, cw_b;
    logic signed [32:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [64:0]       cw_sum;
    logic [4:0]               cnt_m1, cnt_m2;
    logic                     out_free;
    logic                     outside;

    assign o_pop = (r_state == S_IDLE) && i_item_valid;
    assign x_we  = o_pop && (i_item.op == bkmi_pkg::OP_WR_X);
    assign z_we  = o_pop && (i_item.op == bkmi_pkg::OP_WR_Z);
    assign m_we  = o_pop && (i_item.op == bkmi_pkg::OP_WR_MAP);

    bkmi_ram #(.WIDTH(32), .DEPTH(bkmi_pkg::GRID_DEPTH)) u_x_grid (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(i_item.col), .i_wdata(i_item.value),
        .i_raddr(x_raddr), .o_rdata(x_rdata)
    );

    bkmi_ram #(.WIDTH(32), .DEPTH(bkmi_pkg::GRID_DEPTH)) u_z_grid (
        .i_clk(i_clk), .i_we(z_we), .i_waddr(i_item.row), .i_wdata(i_item.value),
        .i_raddr(z_raddr), .o_rdata(z_rdata)
    );

    bkmi_ram #(.WIDTH(32), .DEPTH(bkmi_pkg::MAP_DEPTH)) u_maps (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(i_item.map_addr), .i_wdata(i_item.value),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    assign x_pass = (r_xi < i_col_count) && (r_px >= $signed(x_rdata));
    assign z_pass = (r_zi < i_row_count) && (r_pz <= $signed(z_rdata));
    assign x_stop = r_xdone || !x_pass;
    assign z_stop = r_zdone || !z_pass;

    assign xi_m1 = (r_xi == 7'd0) ? 7'd0 : r_xi - 7'd1;
    assign zi_m1 = (r_zi == 7'd0) ? 7'd0 : r_zi - 7'd1;
    assign x_lim = i_col_count - 7'd2;
    assign z_lim = i_row_count - 7'd2;
    assign n_ix  = (xi_m1 > x_lim) ? x_lim[5:0] : xi_m1[5:0];
    assign n_iz  = (zi_m1 > z_lim) ? z_lim[5:0] : zi_m1[5:0];

    assign outside = (r_px < r_gx0) || (r_px > $signed(x_rdata)) ||
                     (r_pz > r_gz0) || (r_pz < $signed(z_rdata));

    assign x_dc = {r_gx1[31], r_gx1} - {r_gx0[31], r_gx0};
    assign x_da = {r_px[31], r_px} - {x_rdata[31], x_rdata};
    assign z_dc = {r_gz0[31], r_gz0} - {r_gz1[31], r_gz1};
    assign z_da = {z_rdata[31], z_rdata} - {r_pz[31], r_pz};

    assign x_rem2 = {r_xrem, 1'b0};
    assign z_rem2 = {r_zrem, 1'b0};

    assign cnt_m1 = r_cnt - 5'd1;
    assign cnt_m2 = r_cnt - 5'd2;
    assign cw_a   = r_cnt[0] ? r_u : bkmi_pkg::WEIGHT_ONE - r_u;
    assign cw_b   = r_cnt[1] ? r_t : bkmi_pkg::WEIGHT_ONE - r_t;
    assign cw_sum = r_prod + PROD_HALF;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_state == S_CW) begin
            mul_a = $signed({2'b00, cw_a});
            mul_b = $signed({1'b0, cw_b});
        end else begin
            mul_a = $signed({m_rdata[31], m_rdata});
            mul_b = $signed({1'b0, r_cw[cnt_m1[1:0]]});
        end
    end

    always_comb begin
        x_raddr = '0;
        z_raddr = '0;
        m_raddr = {r_order, r_cnt[2], r_iz + 6'(r_cnt[1]), r_ix + 6'(r_cnt[0])};
        unique case (r_state)
            S_RD1: begin
                x_raddr = 6'd1;
                z_raddr = 6'd1;
            end
            S_RDN: begin
                x_raddr = 6'(i_col_count - 7'd1);
                z_raddr = 6'(i_row_count - 7'd1);
            end
            S_SRCH: begin
                x_raddr = 6'(r_xi + 7'd1);
                z_raddr = 6'(r_zi + 7'd1);
            end
            S_GIX: begin
                x_raddr = n_ix;
                z_raddr = n_iz;
            end
            default: begin
                x_raddr = '0;
                z_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= 65'(mul_a) * 65'(mul_b);
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && i_item.op == bkmi_pkg::OP_QUERY) begin
                        r_px    <= i_item.px;
                        r_pz    <= i_item.pz;
                        r_order <= i_item.order;
                        r_state <= S_RD0;
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_gx0   <= $signed(x_rdata);
                    r_gz0   <= $signed(z_rdata);
                    r_state <= S_RDN;
                end
                S_RDN: begin
                    r_gx1   <= $signed(x_rdata);
                    r_gz1   <= $signed(z_rdata);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_outside <= outside;
                    r_xi      <= 7'd0;
                    r_zi      <= 7'd0;
                    r_xdone   <= 1'b0;
                    r_zdone   <= 1'b0;
                    r_state   <= outside ? S_FIN : S_SRCH;
                end
                S_SRCH: begin
                    if (!r_xdone) begin
                        if (x_pass) begin
                            r_xi <= r_xi + 7'd1;
                        end else begin
                            r_xdone <= 1'b1;
                        end
                    end
                    if (!r_zdone) begin
                        if (z_pass) begin
                            r_zi <= r_zi + 7'd1;
                        end else begin
                            r_zdone <= 1'b1;
                        end
                    end
                    if (x_stop && z_stop) begin
                        r_state <= S_GIX;
                    end
                end
                S_GIX: begin
                    r_ix    <= n_ix;
                    r_iz    <= n_iz;
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    r_xok   <= !x_dc[32] && (x_dc != '0) && !x_da[32] && (x_da != '0);
                    r_zok   <= !z_dc[32] && (z_dc != '0) && !z_da[32] && (z_da != '0);
                    r_xstep <= x_dc[31:0];
                    r_xrem  <= x_da[31:0];
                    r_zstep <= z_dc[31:0];
                    r_zrem  <= z_da[31:0];
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    r_xsp   <= !r_xok || (r_xrem >= r_xstep);
                    r_zsp   <= !r_zok || (r_zrem >= r_zstep);
                    r_u     <= (r_xok && r_xrem >= r_xstep) ? bkmi_pkg::WEIGHT_ONE : '0;
                    r_t     <= (r_zok && r_zrem >= r_zstep) ? bkmi_pkg::WEIGHT_ONE : '0;
                    r_cnt   <= 5'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!r_xsp) begin
                        if (x_rem2 >= {1'b0, r_xstep}) begin
                            r_xrem <= 32'(x_rem2 - {1'b0, r_xstep});
                            r_u    <= {r_u[29:0], 1'b1};
                        end else begin
                            r_xrem <= x_rem2[31:0];
                            r_u    <= {r_u[29:0], 1'b0};
                        end
                    end
                    if (!r_zsp) begin
                        if (z_rem2 >= {1'b0, r_zstep}) begin
                            r_zrem <= 32'(z_rem2 - {1'b0, r_zstep});
                            r_t    <= {r_t[29:0], 1'b1};
                        end else begin
                            r_zrem <= z_rem2[31:0];
                            r_t    <= {r_t[29:0], 1'b0};
                        end
                    end
                    if (r_cnt == 5'd29) begin
                        r_cnt   <= 5'd0;
                        r_state <= S_CW;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_CW: begin
                    if (r_cnt != 5'd0) begin
                        r_cw[cnt_m1[1:0]] <= cw_sum[60:30];
                    end
                    if (r_cnt == 5'd4) begin
                        r_cnt   <= 5'd0;
                        r_accx  <= '0;
                        r_accz  <= '0;
                        r_state <= S_MAC;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_MAC: begin
                    if (r_cnt >= 5'd2) begin
                        if (cnt_m2[2]) begin
                            r_accz <= r_accz + 66'(r_prod);
                        end else begin
                            r_accx <= r_accx + 66'(r_prod);
                        end
                    end
                    if (r_cnt == 5'd9) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_ov        <= r_outside;
                        r_kx        <= r_outside ? '0 : sat_kick(r_accx);
                        r_kz        <= r_outside ? '0 : sat_kick(r_accz);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kick_x      = $signed(r_kx);
    assign o_kick_z      = $signed(r_kz);
    assign o_outside_map = r_ov;

endmodule

>>> src/bilinear_kick_map_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_kick_map_interpolator_unit
// Requests enter through a decoding front end and a two-entry queue, so new
// requests are taken while the back end works and while a result waits in
// the output register. The back end handles one request at a time: a grid
// or map write is done as it leaves the queue; a query inside the grid runs
// a linear search that passes one grid point per cycle, a bit-serial
// division and a blend on the single shared multiplier. A query outside
// the grid skips the search, division and blend. Grids and maps are
// undefined until written and need no clearing after reset.
// ----------------------------------------------------------------------------
module bilinear_kick_map_interpolator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [1:0]                          i_map_select,
    input  logic [bkmi_pkg::IDX_W-1:0]          i_column_index,
    input  logic [bkmi_pkg::IDX_W-1:0]          i_row_index,
    input  logic signed [bkmi_pkg::KICK_W-1:0]  i_write_value,
    input  logic signed [bkmi_pkg::POS_W-1:0]   i_position_x,
    input  logic signed [bkmi_pkg::POS_W-1:0]   i_position_z,
    input  logic                                i_kick_order,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bkmi_pkg::KICK_W-1:0]  o_kick_x,
    output logic signed [bkmi_pkg::KICK_W-1:0]  o_kick_z,
    output logic                                o_outside_map,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [bkmi_pkg::COUNT_W-1:0]        i_cfg_data
);

    logic [bkmi_pkg::COUNT_W-1:0] r_column_count;
    logic [bkmi_pkg::COUNT_W-1:0] r_row_count;
    logic [bkmi_pkg::COUNT_W-1:0] col_count;
    logic [bkmi_pkg::COUNT_W-1:0] row_count;
    logic                         q_full;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_valid;
    bkmi_pkg::t_item              push_item;
    bkmi_pkg::t_item              head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= bkmi_pkg::COUNT_RST;
            r_row_count    <= bkmi_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (bkmi_pkg::t_cfg_index'(i_cfg_index))
                bkmi_pkg::CFG_COLUMNS: r_column_count <= i_cfg_data;
                bkmi_pkg::CFG_ROWS:    r_row_count    <= i_cfg_data;
                default:               r_row_count    <= r_row_count;
            endcase
        end
    end

    assign col_count = bkmi_pkg::clamp_count(r_column_count,
                                             7'(bkmi_pkg::MAX_COLUMNS));
    assign row_count = bkmi_pkg::clamp_count(r_row_count,
                                             7'(bkmi_pkg::MAX_ROWS));

    bkmi_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_map_select  (i_map_select),
        .i_column_index(i_column_index),
        .i_row_index   (i_row_index),
        .i_write_value (i_write_value),
        .i_position_x  (i_position_x),
        .i_position_z  (i_position_z),
        .i_kick_order  (i_kick_order),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_item        (push_item)
    );

    bkmi_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (push_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_item (head_item)
    );

    bkmi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (head_item),
        .o_pop        (q_pop),
        .i_col_count  (col_count),
        .i_row_count  (row_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kick_x     (o_kick_x),
        .o_kick_z     (o_kick_z),
        .o_outside_map(o_outside_map)
    );

endmodule

>>> src/bkmi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkmi_checker
// Port-level checks of the bilinear kick map interpolator, bound to the top.
// ----------------------------------------------------------------------------
`include "bilinear_kick_map_interpolator_unit_assert.svh"

module bkmi_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [1:0]                          i_opcode,
    input logic [1:0]                          i_map_select,
    input logic [bkmi_pkg::IDX_W-1:0]          i_column_index,
    input logic [bkmi_pkg::IDX_W-1:0]          i_row_index,
    input logic signed [bkmi_pkg::KICK_W-1:0]  i_write_value,
    input logic signed [bkmi_pkg::POS_W-1:0]   i_position_x,
    input logic signed [bkmi_pkg::POS_W-1:0]   i_position_z,
    input logic                                i_kick_order,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [bkmi_pkg::KICK_W-1:0]  o_kick_x,
    input logic signed [bkmi_pkg::KICK_W-1:0]  o_kick_z,
    input logic                                o_outside_map,
    input logic                                i_cfg_we,
    input logic                                i_cfg_index,
    input logic [bkmi_pkg::COUNT_W-1:0]        i_cfg_data
);

    `BKMI_ASSERT_RST(a_outside_zero, o_out_valid && o_outside_map |-> o_kick_x == '0 && o_kick_z == '0, "outside result carries non-zero kicks")

    `BKMI_ASSERT_RST(a_result_held, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kick_x) && $stable(o_kick_z) && $stable(o_outside_map), "stalled result changed")

    `BKMI_ASSERT_ANY(a_reset_empty, !i_rst_n |=> !o_out_valid && o_in_ready, "block not empty after reset")

endmodule

bind bilinear_kick_map_interpolator_unit bkmi_checker u_bkmi_checker (.*);
